>>> hdl/pd_dfr_pkg.sv
// Types, constants and helper functions shared by the PD deframer receiver.
`timescale 1ns / 1ps
`default_nettype none

package pd_dfr_pkg;

  // Line codes used for start-of-packet detection
  localparam logic [4:0] SYM_SYNC1 = 5'h18;
  localparam logic [4:0] SYM_SYNC2 = 5'h11;
  // Window ordering: oldest symbol in the low bits, newest in bits 19:15
  localparam logic [19:0] SOP_PATTERN = {SYM_SYNC2, SYM_SYNC1, SYM_SYNC1, SYM_SYNC1};

  // Reflected CRC-32 polynomial and preset
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Bit 4 set in a decode entry marks a K-code or an invalid symbol
  localparam logic [4:0] SYM_TO_NIB [32] = '{
    5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10,
    5'h10, 5'h01, 5'h04, 5'h05, 5'h10, 5'h10, 5'h06, 5'h07,
    5'h10, 5'h10, 5'h08, 5'h09, 5'h02, 5'h03, 5'h0A, 5'h0B,
    5'h10, 5'h10, 5'h0C, 5'h0D, 5'h0E, 5'h0F, 5'h00, 5'h10
  };

  // Result kinds
  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_GOOD    = 3'd2,
    KIND_CRC_ERR = 3'd3,
    KIND_SYM_ERR = 3'd4,
    KIND_TRUNC   = 3'd5
  } kind_t;

  // Receiver phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_HEAD = 4'b0010,
    PH_DATA = 4'b0100,
    PH_CRC  = 4'b1000
  } phase_t;

  // Control from the deframer sequencer to the CRC unit
  typedef struct packed {
    logic       init;
    logic       upd;
    logic [3:0] nib;
  } crc_ctl_t;

  // Advance a reflected CRC-32 by one nibble, bit 0 first
  function automatic logic [31:0] crc_nib(input logic [31:0] crc, input logic [3:0] nib);
    logic [31:0] c;
    c = crc ^ {28'd0, nib};
    for (int i = 0; i < 4; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pd_dfr_crc.sv
// Running CRC-32 register, advanced one nibble per header or payload symbol.
`timescale 1ns / 1ps
`default_nettype none

module pd_dfr_crc import pd_dfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire crc_ctl_t    ctl,
  output logic [31:0]      crc
);

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;

  // Preset at packet start, else fold in the decoded nibble
  always_comb begin
    crc_nxt = crc_r;
    if (ctl.init) begin
      crc_nxt = CRC_INIT;
    end else if (ctl.upd) begin
      crc_nxt = crc_nib(crc_r, ctl.nib);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

`default_nettype wire

>>> hdl/pd_message_deframer_rx_core.sv
// Top level of the USB PD 4b5b packet receiver with CRC-32 check.
//
//  channel  direction  signals                                        transaction
//  in_      sink       in_symbol[4:0], in_line_idle                   one line symbol
//  out_     source     out_kind, out_value, out_word_index, out_last  header/word/status
//
// One symbol per cycle sustained while the output register is not stalled; an accepted
// symbol is captured in the input register, and its result (if any) is then written to
// the output register, which raises out_valid. Symbols that give no result
// still pass through the input register and update the state.
// The output register stalls the input register only while a result is held.
// Synchronous active-low reset returns the receiver to start-of-packet hunting.
`timescale 1ns / 1ps
`default_nettype none

module pd_message_deframer_rx_core import pd_dfr_pkg::*; #(
  parameter int MAX_DATA_WORDS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_symbol,
  input  wire logic        in_line_idle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_value,
  output logic [2:0]       out_word_index,
  output logic             out_last
);

  localparam logic [2:0] MAX_WORDS = 3'(MAX_DATA_WORDS);

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [4:0] s1_symbol_r;
  logic       s1_idle_r;
  logic       s1_adv, s1_fire, in_fire;

  // Receiver state
  phase_t      phase_r, phase_nxt;
  logic [19:0] win_r, win_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  exp_r, exp_nxt;
  logic [2:0]  done_r, done_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r;
  logic [31:0] out_value_r;
  logic [2:0]  out_idx_r;
  logic        out_last_r;

  // Result of the current symbol
  logic        res_vld;
  kind_t       res_kind;
  logic [31:0] res_value;
  logic [2:0]  res_idx;
  logic        res_last;

  // Decode and CRC signals
  crc_ctl_t    crc_ctl;
  logic [31:0] crc;
  logic [4:0]  nib_raw;
  logic [19:0] win_shift;
  logic [31:0] shift_new;
  logic [2:0]  cnt_new;
  logic [2:0]  done_new;
  logic [2:0]  hdr_cnt;

  // Handshake: the input register moves whenever the output register can take
  assign s1_adv   = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_symbol_r <= in_symbol;
      s1_idle_r   <= in_line_idle;
    end
  end

  // Symbol decode helpers
  assign nib_raw   = SYM_TO_NIB[s1_symbol_r];
  assign win_shift = {s1_symbol_r, win_r[19:5]};
  assign shift_new = {nib_raw[3:0], shift_r[31:4]};
  assign cnt_new   = cnt_r + 3'd1;
  assign done_new  = done_r + 3'd1;
  assign hdr_cnt   = (shift_new[30:28] > MAX_WORDS) ? MAX_WORDS : shift_new[30:28];

  // Packet sequencer
  always_comb begin
    phase_nxt   = phase_r;
    win_nxt     = win_r;
    shift_nxt   = shift_r;
    cnt_nxt     = cnt_r;
    exp_nxt     = exp_r;
    done_nxt    = done_r;
    res_vld     = 1'b0;
    res_kind    = KIND_HEADER;
    res_value   = 32'd0;
    res_idx     = 3'd0;
    res_last    = 1'b0;
    crc_ctl     = '0;
    crc_ctl.nib = nib_raw[3:0];

    if (s1_fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (s1_idle_r) begin
            win_nxt = 20'd0;
          end else if (win_shift == SOP_PATTERN) begin
            phase_nxt    = PH_HEAD;
            win_nxt      = 20'd0;
            shift_nxt    = 32'd0;
            cnt_nxt      = 3'd0;
            exp_nxt      = 3'd0;
            done_nxt     = 3'd0;
            crc_ctl.init = 1'b1;
          end else begin
            win_nxt = win_shift;
          end
        end
        PH_HEAD, PH_DATA, PH_CRC: begin
          if (s1_idle_r || nib_raw[4]) begin
            // Line went idle or a non-data code: abort the packet
            phase_nxt = PH_HUNT;
            win_nxt   = 20'd0;
            shift_nxt = 32'd0;
            cnt_nxt   = 3'd0;
            exp_nxt   = 3'd0;
            done_nxt  = 3'd0;
            res_vld   = 1'b1;
            res_last  = 1'b1;
            if (s1_idle_r) begin
              res_kind = KIND_TRUNC;
            end else begin
              res_kind  = KIND_SYM_ERR;
              res_value = {27'd0, s1_symbol_r};
            end
          end else begin
            shift_nxt   = shift_new;
            cnt_nxt     = cnt_new;
            crc_ctl.upd = (phase_r != PH_CRC);
            if (phase_r == PH_HEAD) begin
              if (cnt_new == 3'd4) begin
                cnt_nxt   = 3'd0;
                shift_nxt = 32'd0;
                exp_nxt   = hdr_cnt;
                done_nxt  = 3'd0;
                phase_nxt = (hdr_cnt != 3'd0) ? PH_DATA : PH_CRC;
                res_vld   = 1'b1;
                res_kind  = KIND_HEADER;
                res_value = {16'd0, shift_new[31:16]};
              end
            end else if (cnt_new == 3'd0) begin
              if (phase_r == PH_DATA) begin
                shift_nxt = 32'd0;
                done_nxt  = done_new;
                if (done_new >= exp_r) begin
                  phase_nxt = PH_CRC;
                end
                res_vld   = 1'b1;
                res_kind  = KIND_PAYLOAD;
                res_value = shift_new;
                res_idx   = done_r;
              end else begin
                // Received CRC complete: compare with the complemented running CRC
                phase_nxt = PH_HUNT;
                win_nxt   = 20'd0;
                shift_nxt = 32'd0;
                cnt_nxt   = 3'd0;
                exp_nxt   = 3'd0;
                done_nxt  = 3'd0;
                res_vld   = 1'b1;
                res_last  = 1'b1;
                res_value = shift_new;
                res_kind  = (shift_new == ~crc) ? KIND_GOOD : KIND_CRC_ERR;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      win_r   <= 20'd0;
      shift_r <= 32'd0;
      cnt_r   <= 3'd0;
      exp_r   <= 3'd0;
      done_r  <= 3'd0;
    end else begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      exp_r   <= exp_nxt;
      done_r  <= done_nxt;
    end
  end

  // Running CRC over header and payload nibbles
  pd_dfr_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .crc   (crc)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_fire && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_vld) begin
      out_kind_r  <= res_kind;
      out_value_r <= res_value;
      out_idx_r   <= res_idx;
      out_last_r  <= res_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_value      = out_value_r;
  assign out_word_index = out_idx_r;
  assign out_last       = out_last_r;

  // Checks
  a_last_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_kind_r != KIND_HEADER && out_kind_r != KIND_PAYLOAD)))
    else $error("last flag does not match result kind");

  a_idx_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_PAYLOAD) |-> (out_idx_r == 3'd0))
    else $error("word index set on non-payload result");

  a_words_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (done_r < exp_r && exp_r <= MAX_WORDS))
    else $error("payload word counter out of range");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEAD) |-> (cnt_r < 3'd4))
    else $error("header nibble count overran");

  a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && phase_r == PH_HUNT) |-> !res_vld)
    else $error("result produced while hunting");

endmodule

`default_nettype wire

>>> sim/pd_message_deframer_rx_core_test.sv
// Self-checking testbench for the PD 4b5b packet receiver with CRC-32 check.
`timescale 1ns / 1ps

module pd_message_deframer_rx_core_test;
  import pd_dfr_pkg::*;

  localparam int MAX_WORDS    = 7;
  localparam int RANDOM_ITEMS = 1200;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam logic [4:0] NOT_DATA = 5'h10;

  typedef enum int {FLT_NONE, FLT_CRC, FLT_SYM, FLT_IDLE} fault_t;

  typedef struct packed {
    logic [4:0] sym;
    logic       idle;
  } line_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [2:0]  idx;
    logic        last;
  } rx_result_t;

  // DUT connections
  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  in_symbol = 5'd0;
  logic        in_line_idle = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_value;
  logic [2:0]  out_word_index;
  logic        out_last;

  // Stimulus and scoreboard storage
  line_item_t line_q[$];
  rx_result_t expected_q[$];
  logic [3:0] pkt_nibs[$];
  int         n_items = 0;
  int         n_sent = 0;
  int         n_errors = 0;
  int         cycles = 0;
  int         mode = 0;
  logic       in_fire = 1'b0;
  logic       hold_off = 1'b0;

  // Receiver shadow state
  phase_t      rx_phase = PH_HUNT;
  logic [19:0] sop_win = '0;
  logic [31:0] nib_shift = '0;
  logic [2:0]  nib_cnt = '0;
  logic [2:0]  words_exp = '0;
  logic [2:0]  words_done = '0;
  logic [31:0] crc_acc = CRC_INIT;

  pd_message_deframer_rx_core #(.MAX_DATA_WORDS(MAX_WORDS)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_symbol      (in_symbol),
    .in_line_idle   (in_line_idle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_word_index (out_word_index),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // 4b5b data code for each nibble
  function automatic logic [4:0] nib_to_sym(input logic [3:0] n);
    logic [4:0] s;
    case (n)
      4'h0: s = 5'h1E;
      4'h1: s = 5'h09;
      4'h2: s = 5'h14;
      4'h3: s = 5'h15;
      4'h4: s = 5'h0A;
      4'h5: s = 5'h0B;
      4'h6: s = 5'h0E;
      4'h7: s = 5'h0F;
      4'h8: s = 5'h12;
      4'h9: s = 5'h13;
      4'hA: s = 5'h16;
      4'hB: s = 5'h17;
      4'hC: s = 5'h1A;
      4'hD: s = 5'h1B;
      4'hE: s = 5'h1C;
      default: s = 5'h1D;
    endcase
    return s;
  endfunction

  // Reverse lookup; anything that is not a data code flags NOT_DATA
  function automatic logic [4:0] sym_to_nib(input logic [4:0] s);
    logic [4:0] r;
    r = NOT_DATA;
    for (int i = 0; i < 16; i++) begin
      if (nib_to_sym(4'(i)) == s) r = {1'b0, 4'(i)};
    end
    return r;
  endfunction

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  task automatic queue_line(input logic [4:0] sym, input logic idle);
    line_item_t it;
    it.sym  = sym;
    it.idle = idle;
    line_q.push_back(it);
  endtask

  task automatic queue_sop();
    repeat (3) queue_line(SYM_SYNC1, 1'b0);
    queue_line(SYM_SYNC2, 1'b0);
  endtask

  task automatic push_nibbles(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) pkt_nibs.push_back(v[4*i +: 4]);
  endtask

  // Framed packet; a fault flips a CRC bit, or cuts it short with a bad code or idle
  task automatic add_packet(input logic [15:0] hdr, input fault_t fault, input int cut);
    logic [31:0] crc;
    logic [31:0] word;
    logic [4:0]  bad;
    int          nwords;
    int          n_keep;
    pkt_nibs.delete();
    nwords = hdr[14:12];
    if (nwords > MAX_WORDS) nwords = MAX_WORDS;
    crc = CRC_INIT;
    push_nibbles({16'd0, hdr}, 4);
    crc = crc_byte(crc, hdr[7:0]);
    crc = crc_byte(crc, hdr[15:8]);
    for (int w = 0; w < nwords; w++) begin
      word = $urandom;
      push_nibbles(word, 8);
      for (int b = 0; b < 4; b++) crc = crc_byte(crc, word[8*b +: 8]);
    end
    crc = ~crc;
    if (fault == FLT_CRC) crc = crc ^ (32'd1 << $urandom_range(31));
    push_nibbles(crc, 8);
    n_keep = pkt_nibs.size();
    if (fault == FLT_SYM || fault == FLT_IDLE) begin
      n_keep = (cut < 0) ? int'($urandom_range(pkt_nibs.size() - 1)) : cut;
    end
    queue_sop();
    for (int i = 0; i < n_keep; i++) queue_line(nib_to_sym(pkt_nibs[i]), 1'b0);
    if (fault == FLT_SYM) begin
      do bad = 5'($urandom_range(31)); while (sym_to_nib(bad) != NOT_DATA);
      queue_line(bad, 1'b0);
    end else if (fault == FLT_IDLE) begin
      queue_line(5'($urandom_range(31)), 1'b1);
    end
  endtask

  task automatic push_result(input kind_t k, input logic [31:0] v, input logic [2:0] i,
                             input logic l);
    rx_result_t e;
    e.kind  = k;
    e.value = v;
    e.idx   = i;
    e.last  = l;
    expected_q.push_back(e);
  endtask

  task automatic close_packet();
    rx_phase   = PH_HUNT;
    sop_win    = '0;
    nib_shift  = '0;
    nib_cnt    = '0;
    words_exp  = '0;
    words_done = '0;
  endtask

  // Shadow receiver: advance on one accepted symbol, queue what it should emit
  task automatic deframe_symbol(input logic [4:0] sym, input logic idle);
    logic [4:0]  nib;
    logic [15:0] hdr;
    logic [2:0]  cnt;
    if (rx_phase == PH_HUNT) begin
      if (idle) begin
        sop_win = '0;
      end else begin
        sop_win = {sym, sop_win[19:5]};
        if (sop_win == SOP_PATTERN) begin
          close_packet();
          rx_phase = PH_HEAD;
          crc_acc  = CRC_INIT;
        end
      end
    end else if (idle) begin
      close_packet();
      push_result(KIND_TRUNC, 32'd0, 3'd0, 1'b1);
    end else begin
      nib = sym_to_nib(sym);
      if (nib == NOT_DATA) begin
        close_packet();
        push_result(KIND_SYM_ERR, {27'd0, sym}, 3'd0, 1'b1);
      end else begin
        nib_shift = {nib[3:0], nib_shift[31:4]};
        nib_cnt   = nib_cnt + 3'd1;
        if (rx_phase == PH_HEAD) begin
          // header complete after four nibbles
          if (nib_cnt == 3'd4) begin
            hdr       = nib_shift[31:16];
            nib_cnt   = '0;
            nib_shift = '0;
            crc_acc   = crc_byte(crc_acc, hdr[7:0]);
            crc_acc   = crc_byte(crc_acc, hdr[15:8]);
            cnt       = hdr[14:12];
            if (cnt > MAX_WORDS) cnt = 3'(MAX_WORDS);
            words_exp  = cnt;
            words_done = '0;
            rx_phase   = (cnt != 3'd0) ? PH_DATA : PH_CRC;
            push_result(KIND_HEADER, {16'd0, hdr}, 3'd0, 1'b0);
          end
        end else if (nib_cnt == 3'd0) begin
          if (rx_phase == PH_DATA) begin
            push_result(KIND_PAYLOAD, nib_shift, words_done, 1'b0);
            for (int b = 0; b < 4; b++) crc_acc = crc_byte(crc_acc, nib_shift[8*b +: 8]);
            nib_shift  = '0;
            words_done = words_done + 3'd1;
            if (words_done >= words_exp) rx_phase = PH_CRC;
          end else begin
            push_result((nib_shift == ~crc_acc) ? KIND_GOOD : KIND_CRC_ERR,
                        nib_shift, 3'd0, 1'b1);
            close_packet();
          end
        end
      end
    end
  endtask

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("mismatch %0d: %s", n_errors, msg);
  endtask

  // Driver: symbol source and result sink, both changing on the falling edge
  always @(negedge clk) begin
    line_item_t it;
    int         snd_idle;
    int         rcv_idle;
    if (rst_n) begin
      mode = (n_sent < n_items / 3) ? 0 : (n_sent < 2 * n_items / 3) ? 1 : 2;
      snd_idle = (mode == 0) ? 37 : (mode == 1) ? 62 : 0;
      rcv_idle = (mode == 0) ? 62 : (mode == 1) ? 37 : 0;
      if (!in_valid || in_fire) begin
        if (line_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
          it = line_q.pop_front();
          in_valid     <= 1'b1;
          in_symbol    <= it.sym;
          in_line_idle <= it.idle;
          n_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= rcv_idle);
    end
  end

  // Long receiver stall once the sender runs flat out
  initial begin
    wait (mode == 2);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Monitor: check results, then feed accepted symbols to the shadow receiver
  always @(posedge clk) begin
    rx_result_t got;
    rx_result_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got.kind  = kind_t'(out_kind);
        got.value = out_value;
        got.idx   = out_word_index;
        got.last  = out_last;
        if (expected_q.size() == 0) begin
          flag_error($sformatf("unexpected result kind %0d value %h idx %0d last %b",
                               out_kind, out_value, out_word_index, out_last));
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            flag_error($sformatf("kind %0d value %h idx %0d last %b, expected %0d %h %0d %b",
                                 out_kind, out_value, out_word_index, out_last,
                                 want.kind, want.value, want.idx, want.last));
          end
        end
      end
      if (in_valid && in_ready) deframe_symbol(in_symbol, in_line_idle);
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("pd_message_deframer_rx_core_test: errors");
      $finish;
    end
  end

  // Stimulus, reset and end of test
  initial begin
    logic [15:0] hdr;
    fault_t      fault;
    int          r;
    int          n_directed;

    // idle and a low code while hunting, then good, truncated and bad-symbol packets
    queue_line(5'h00, 1'b1);
    queue_line(5'h00, 1'b0);
    add_packet(16'h8FFF, FLT_NONE, 0);
    queue_sop();
    queue_line(5'h1F, 1'b1);
    queue_sop();
    queue_line(5'h1F, 1'b0);
    n_directed = line_q.size();

    // random packets separated by line noise and near-miss sync runs
    while (line_q.size() < n_directed + RANDOM_ITEMS) begin
      repeat ($urandom_range(4)) queue_line(5'($urandom_range(31)), $urandom_range(99) < 15);
      case ($urandom_range(9))
        0: begin
          repeat (2) queue_line(SYM_SYNC1, 1'b0);
          queue_line(SYM_SYNC2, 1'b0);
        end
        1: begin
          repeat (3) queue_line(SYM_SYNC1, 1'b0);
          queue_line(nib_to_sym(4'($urandom)), 1'b0);
        end
        default: begin
          hdr = 16'($urandom);
          if ($urandom_range(1)) hdr[14:12] = 3'($urandom_range(2));
          r = $urandom_range(99);
          fault = (r < 70) ? FLT_NONE : (r < 80) ? FLT_CRC : (r < 90) ? FLT_SYM : FLT_IDLE;
          add_packet(hdr, fault, -1);
        end
      endcase
    end
    n_items = line_q.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (line_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) flag_error("results still outstanding at end of run");

    if (n_errors == 0) begin
      $display("pd_message_deframer_rx_core_test: clean");
    end else begin
      $display("pd_message_deframer_rx_core_test: errors");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pd_dfr_pkg.sv
hdl/pd_dfr_crc.sv
hdl/pd_message_deframer_rx_core.sv
sim/pd_message_deframer_rx_core_test.sv
